// ===== rtl/core/pemp_pkg.sv =====
// shared types, constants and helpers for the prefix expression evaluator
// no dependencies; imported by every module of the block
package pemp_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned FuncW      = 3;
  localparam int unsigned OperandW   = 63;
  localparam int unsigned ValueW     = 30;
  localparam int unsigned RedInW     = 60;

  // modulus and barrett factor floor(2^60 / p)
  localparam logic [ValueW-1:0] Prime      = 30'd1000000007;
  localparam logic [63:0]       BarrettM64 = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0]       BarrettM   = BarrettM64[30:0];

  // token kind codes on the input
  localparam logic [FuncW-1:0] FuncNum = 3'd0;
  localparam logic [FuncW-1:0] FuncAdd = 3'd1;
  localparam logic [FuncW-1:0] FuncSub = 3'd2;
  localparam logic [FuncW-1:0] FuncMul = 3'd3;

  typedef enum logic [2:0] {
    OpNum,
    OpAdd,
    OpSub,
    OpMul,
    OpBad
  } op_e;

  typedef enum logic [2:0] {
    BIdle,
    BRead,
    BMulW,
    BRed,
    BEmit
  } back_state_e;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [OperandW-1:0] operand_value;
    logic                final_token;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] expr_value;
    logic              is_invalid;
  } out_item_t;

  // classified token, value already reduced mod p
  typedef struct packed {
    op_e               op;
    logic [ValueW-1:0] value;
    logic              final_tok;
  } tok_t;

  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_beat_t;

  // sideband carried alongside the two reduction passes
  typedef struct packed {
    op_e               op;
    logic              final_tok;
    logic [ValueW-1:0] lo;
  } ftag1_t;

  typedef struct packed {
    op_e  op;
    logic final_tok;
  } ftag2_t;

  // one conditional subtract of p
  function automatic logic [31:0] cond_sub(input logic [31:0] v);
    logic [31:0] p32;
    p32 = {2'b00, Prime};
    return (v >= p32) ? (v - p32) : v;
  endfunction

endpackage

// ===== rtl/core/prefix_expression_mod_prime_evaluator.sv =====
// path: front pipe (input register, barrett pass, middle register, barrett pass), then the
//   stack unit and the result register; the front takes a token every cycle unless a
//   finished token meets the full 4-entry queue; stack unit: number or bad token in idle,
//   add/sub idle and read, multiply idle, read, wait and the barrett pipe; final adds emit
// reset: asynchronous active low; clears stack count, error flag, queue and valid bits
// stack memory contents are not cleared; only written entries are ever used
module prefix_expression_mod_prime_evaluator #(
  parameter int unsigned STACK_DEPTH = pemp_pkg::StackDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pemp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pemp_pkg::out_item_t out_data_o
);
  import pemp_pkg::*;

  // front to queue
  tok_beat_t push;
  logic      q_full;
  // queue to back
  tok_beat_t head;
  logic      pop;

  // classify tokens and reduce number operands mod p in two barrett passes
  pemp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (push)
  );

  // decouples the fixed-rate front from the variable-rate stack unit
  pemp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // stack unit: top held in a register, the rest in a synchronous memory
  pemp_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/pemp_reduce.sv =====
// pipelined barrett reduction of a 60-bit value mod p, four register stages
// depends on pemp_pkg; x_i must come straight from a register
module pemp_reduce #(
  parameter int unsigned TagW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [pemp_pkg::RedInW-1:0] x_i,
  input  logic [TagW-1:0]             tag_i,
  output logic                        valid_o,
  output logic [pemp_pkg::ValueW-1:0] r_o,
  output logic [TagW-1:0]             tag_o
);
  import pemp_pkg::*;

  logic [3:0]        v_q;
  logic [61:0]       qm;
  logic [60:0]       qp;
  logic [30:0]       q3_q;
  logic [31:0]       xa_q;
  logic [31:0]       xb_q;
  logic [31:0]       qp_q;
  logic [31:0]       r_q;
  logic [31:0]       r1_q;
  logic [31:0]       r_fin;
  logic [TagW-1:0]   tag_q [4];

  // quotient estimate from the top 31 bits
  assign qm = {31'b0, x_i[59:29]} * {31'b0, BarrettM};
  assign qp = {30'b0, q3_q} * {31'b0, Prime};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q3_q     <= qm[61:31];
      xa_q     <= x_i[31:0];
      qp_q     <= qp[31:0];
      xb_q     <= xa_q;
      // remainder is below 3p, fits in 32 bits
      r_q      <= xb_q - qp_q;
      r1_q     <= cond_sub(r_q);
      tag_q[0] <= tag_i;
      tag_q[1] <= tag_q[0];
      tag_q[2] <= tag_q[1];
      tag_q[3] <= tag_q[2];
    end
  end

  assign r_fin   = cond_sub(r1_q);
  assign r_o     = r_fin[ValueW-1:0];
  assign valid_o = v_q[3];
  assign tag_o   = tag_q[3];

`ifndef SYNTHESIS
  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (r_fin < {2'b00, Prime}))
    else $error("reduction result not below p");
`endif

endmodule

// ===== rtl/core/pemp_front.sv =====
// front end: accepts tokens, classifies the kind and reduces numbers mod p
// depends on pemp_pkg and pemp_reduce; feeds the token queue
module pemp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pemp_pkg::in_item_t    in_data_i,
  input  logic                  full_i,
  output pemp_pkg::tok_beat_t   push_o
);
  import pemp_pkg::*;

  localparam int unsigned Tag1W = $bits(ftag1_t);
  localparam int unsigned Tag2W = $bits(ftag2_t);

  logic                en;
  logic                s0_valid_q;
  in_item_t            s0_q;
  ftag1_t              tag1;
  logic [Tag1W-1:0]    tag1_raw;
  ftag1_t              tag1_o;
  logic                red1_valid;
  logic [ValueW-1:0]   red1_r;
  logic                s1_valid_q;
  logic [RedInW-1:0]   s1_x_q;
  ftag2_t              s1_tag_q;
  logic [Tag2W-1:0]    tag2_raw;
  ftag2_t              tag2_o;
  logic                red2_valid;
  logic [ValueW-1:0]   red2_r;

  function automatic op_e classify(input logic [FuncW-1:0] f);
    op_e o;
    case (f)
      FuncNum: o = OpNum;
      FuncAdd: o = OpAdd;
      FuncSub: o = OpSub;
      FuncMul: o = OpMul;
      default: o = OpBad;
    endcase
    return o;
  endfunction

  // whole pipe holds only when a finished token cannot enter the queue
  assign en         = !(red2_valid && full_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
      s1_valid_q <= red1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q     <= in_data_i;
      s1_x_q   <= {red1_r, tag1_o.lo};
      s1_tag_q <= '{op: tag1_o.op, final_tok: tag1_o.final_tok};
    end
  end

  assign tag1 = '{op: classify(s0_q.func), final_tok: s0_q.final_token,
                  lo: s0_q.operand_value[ValueW-1:0]};

  // first pass folds the upper 33 bits
  pemp_reduce #(.TagW(Tag1W)) u_red1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .x_i     ({27'b0, s0_q.operand_value[OperandW-1:ValueW]}),
    .tag_i   (tag1),
    .valid_o (red1_valid),
    .r_o     (red1_r),
    .tag_o   (tag1_raw)
  );
  assign tag1_o = ftag1_t'(tag1_raw);

  // second pass reduces hi' * 2^30 + lo
  pemp_reduce #(.TagW(Tag2W)) u_red2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .x_i     (s1_x_q),
    .tag_i   (s1_tag_q),
    .valid_o (red2_valid),
    .r_o     (red2_r),
    .tag_o   (tag2_raw)
  );
  assign tag2_o = ftag2_t'(tag2_raw);

  always_comb begin
    push_o.valid         = red2_valid && !full_i;
    push_o.tok.op        = tag2_o.op;
    push_o.tok.final_tok = tag2_o.final_tok;
    push_o.tok.value     = (tag2_o.op == OpNum) ? red2_r : '0;
  end

endmodule

// ===== rtl/core/pemp_queue.sv =====
// short token queue between front and back
// depends on pemp_pkg
module pemp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pemp_pkg::tok_beat_t push_i,
  output logic                full_o,
  input  logic                pop_i,
  output pemp_pkg::tok_beat_t head_o
);
  import pemp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tok_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.tok;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.tok   = mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/pemp_back.sv =====
// back end: operand stack, add/sub/mul mod p, error tracking, result register
// depends on pemp_pkg and pemp_reduce; takes tokens from the queue
module pemp_back #(
  parameter int unsigned STACK_DEPTH = pemp_pkg::StackDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pemp_pkg::tok_beat_t   head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pemp_pkg::out_item_t   out_data_o
);
  import pemp_pkg::*;

  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);

  back_state_e       state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              err_q, err_d;
  logic [ValueW-1:0] top_q, top_d;
  op_e               op_q, op_d;
  logic              fin_q, fin_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // entries below the top; the top itself lives in top_q
  logic [ValueW-1:0] mem [STACK_DEPTH];
  logic [ValueW-1:0] rd_q;
  logic [2*ValueW-1:0] prod_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [AddrW-1:0]  mem_raddr;
  logic [CountW-1:0] cnt_m1;
  logic [CountW-1:0] cnt_m2;
  logic              slot_free;
  logic [ValueW:0]   sum;
  logic [ValueW:0]   diff;
  logic [ValueW:0]   diff_fix;
  logic [31:0]       sum_red;
  logic              red_valid;
  logic              red_vo;
  logic [ValueW-1:0] red_r;
  logic              red_tag_unused;

  assign cnt_m1    = count_q - CountW'(1);
  assign cnt_m2    = count_q - CountW'(2);
  assign mem_waddr = cnt_m1[AddrW-1:0];
  assign mem_raddr = cnt_m2[AddrW-1:0];
  assign slot_free = !out_valid_q || !out_stall_i;

  // a is the top, b the entry below it
  assign sum      = {1'b0, top_q} + {1'b0, rd_q};
  assign sum_red  = cond_sub({1'b0, sum});
  assign diff     = {1'b0, top_q} - {1'b0, rd_q};
  assign diff_fix = diff + {1'b0, Prime};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    top_d       = top_q;
    op_d        = op_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    red_valid   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BIdle: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          op_d    = head_i.tok.op;
          fin_d   = head_i.tok.final_tok;
          state_d = head_i.tok.final_tok ? BEmit : BIdle;
          case (head_i.tok.op)
            OpNum: begin
              if (count_q == CountW'(STACK_DEPTH)) begin
                err_d = 1'b1;
              end else begin
                mem_we  = (count_q != '0);
                top_d   = head_i.tok.value;
                count_d = count_q + CountW'(1);
              end
            end
            OpAdd, OpSub, OpMul: begin
              if (count_q < CountW'(2)) begin
                err_d = 1'b1;
              end else begin
                state_d = BRead;
              end
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
      end
      BRead: begin
        case (op_q)
          OpAdd: begin
            top_d   = sum_red[ValueW-1:0];
            count_d = cnt_m1;
            state_d = fin_q ? BEmit : BIdle;
          end
          OpSub: begin
            top_d   = diff[ValueW] ? diff_fix[ValueW-1:0] : diff[ValueW-1:0];
            count_d = cnt_m1;
            state_d = fin_q ? BEmit : BIdle;
          end
          OpMul: begin
            state_d = BMulW;
          end
          default: begin
            state_d = BIdle;
          end
        endcase
      end
      BMulW: begin
        red_valid = 1'b1;
        state_d   = BRed;
      end
      BRed: begin
        if (red_vo) begin
          top_d   = red_r;
          count_d = cnt_m1;
          state_d = fin_q ? BEmit : BIdle;
        end
      end
      BEmit: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.is_invalid = err_q || (count_q != CountW'(1));
          out_d.expr_value = out_d.is_invalid ? '0 : top_q;
          count_d          = '0;
          err_d            = 1'b0;
          state_d          = BIdle;
        end
      end
      default: begin
        state_d = BIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    op_q   <= op_d;
    fin_q  <= fin_d;
    out_q  <= out_d;
    prod_q <= {ValueW'(0), top_q} * {ValueW'(0), rd_q};
  end

  // stack memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= top_q;
    end
    rd_q <= mem[mem_raddr];
  end

  pemp_reduce #(.TagW(1)) u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (1'b1),
    .valid_i (red_valid),
    .x_i     (prod_q),
    .tag_i   (1'b0),
    .valid_o (red_vo),
    .r_o     (red_r),
    .tag_o   (red_tag_unused)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BEmit && slot_free) |=> (count_q == '0 && !err_q))
    else $error("stack not cleared after result");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == BEmit))
    else $error("result beat raised outside emit");

  a_pop_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BIdle && head_i.valid))
    else $error("queue popped while busy");
`endif

endmodule
